/* rtl/core/trd_pkg.sv */
// Shared types, register indexes and a helper function for the TGA RLE pixel decoder.
`timescale 1ns / 1ps
`default_nettype none
package trd_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned DimW    = 16;
  localparam int unsigned PixCntW = 32;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = $clog2(QDepth);

  localparam logic [CfgIdxW-1:0] RegImageWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRleMode     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegHasAlpha    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPremultiply = 3'd4;

  localparam logic [7:0] HdrCountMask = 8'h7f;
  localparam logic [7:0] OpaqueAlpha  = 8'hff;

  typedef struct packed {
    logic [DimW-1:0] image_width;
    logic [DimW-1:0] image_height;
    logic            rle_mode;
    logic            has_alpha;
    logic            premultiply;
  } cfg_t;

  // One decoded pixel as it travels from the front to the back.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic       image_done;
    logic       run_clipped;
    logic       premultiply;
  } pix_t;

  typedef struct packed {
    logic [15:0] red_prod;
    logic [15:0] green_prod;
    logic [15:0] blue_prod;
    logic [7:0]  alpha;
    logic [7:0]  repeat_count;
    logic        image_done;
    logic        run_clipped;
  } prod_t;

  typedef struct packed {
    logic push;
  } q_status_t;

  // Exact floor(x / 255) for any product of two bytes.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return s[15:8];
  endfunction

endpackage
`default_nettype wire

/* rtl/core/trd_front.sv */
// Front end: configuration registers, packet parsing and pixel assembly.
`timescale 1ns / 1ps
`default_nettype none
module trd_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [trd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [trd_pkg::DimW-1:0]    cfg_data_i,
  input  wire logic                        push_i,
  input  wire logic [7:0]                  data_byte_i,
  output logic                             full_o,
  input  wire logic                        q_full_i,
  output trd_pkg::q_status_t               q_ctl_o,
  output trd_pkg::pix_t                    q_item_o
);

  trd_pkg::cfg_t                       cfg_q, cfg_d;
  logic                                load_q, load_d;
  logic                                expect_hdr_q, expect_hdr_d;
  logic                                is_repeat_q, is_repeat_d;
  logic [7:0]                          pkt_left_q, pkt_left_d;
  logic [1:0]                          byte_idx_q, byte_idx_d;
  logic [23:0]                         held_q, held_d;
  logic [trd_pkg::PixCntW-1:0]         pix_left_q, pix_left_d;
  logic [trd_pkg::DimW-1:0]            w_eff, h_eff;
  logic [trd_pkg::PixCntW-1:0]         total_pix;
  logic [trd_pkg::PixCntW-1:0]         pix_left_nxt;
  logic [7:0]                          cnt;
  logic [7:0]                          pkt_left_nxt;
  logic                                clipped;
  logic                                cfg_wr;
  logic                                accept;
  logic [1:0]                          last_idx;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign full_o      = q_full_i || load_q;
  assign accept      = push_i && !full_o;
  assign w_eff       = (cfg_q.image_width == '0) ? trd_pkg::DimW'(1) : cfg_q.image_width;
  assign h_eff       = (cfg_q.image_height == '0) ? trd_pkg::DimW'(1) : cfg_q.image_height;
  assign total_pix   = trd_pkg::PixCntW'(w_eff) * trd_pkg::PixCntW'(h_eff);
  assign last_idx    = cfg_q.has_alpha ? 2'd3 : 2'd2;

  always_comb begin
    cfg_d        = cfg_q;
    load_d       = 1'b0;
    expect_hdr_d = expect_hdr_q;
    is_repeat_d  = is_repeat_q;
    pkt_left_d   = pkt_left_q;
    byte_idx_d   = byte_idx_q;
    held_d       = held_q;
    pix_left_d   = load_q ? total_pix : pix_left_q;
    cnt          = 8'd1;
    clipped      = 1'b0;
    pkt_left_nxt = pkt_left_q;
    pix_left_nxt = pix_left_q;
    q_ctl_o.push = 1'b0;

    q_item_o.blue         = held_q[7:0];
    q_item_o.green        = held_q[15:8];
    q_item_o.red          = cfg_q.has_alpha ? held_q[23:16] : data_byte_i;
    q_item_o.alpha        = cfg_q.has_alpha ? data_byte_i : trd_pkg::OpaqueAlpha;
    q_item_o.premultiply  = cfg_q.premultiply;
    q_item_o.repeat_count = cnt;
    q_item_o.image_done   = 1'b0;
    q_item_o.run_clipped  = 1'b0;

    if (cfg_q.rle_mode) begin
      if (is_repeat_q) begin
        if (trd_pkg::PixCntW'(pkt_left_q) > pix_left_q) begin
          cnt     = pix_left_q[7:0];
          clipped = 1'b1;
        end else begin
          cnt = pkt_left_q;
        end
        pkt_left_nxt = 8'd0;
      end else begin
        pkt_left_nxt = (pkt_left_q != 8'd0) ? pkt_left_q - 8'd1 : 8'd0;
        clipped      = (pix_left_q == trd_pkg::PixCntW'(1)) && (pkt_left_nxt != 8'd0);
      end
    end
    pix_left_nxt          = pix_left_q - trd_pkg::PixCntW'(cnt);
    q_item_o.repeat_count = cnt;
    q_item_o.run_clipped  = clipped;
    q_item_o.image_done   = (pix_left_nxt == '0);

    if (cfg_wr) begin
      unique case (cfg_index_i)
        trd_pkg::RegImageWidth:  cfg_d.image_width  = cfg_data_i;
        trd_pkg::RegImageHeight: cfg_d.image_height = cfg_data_i;
        trd_pkg::RegRleMode:     cfg_d.rle_mode     = cfg_data_i[0];
        trd_pkg::RegHasAlpha:    cfg_d.has_alpha    = cfg_data_i[0];
        trd_pkg::RegPremultiply: cfg_d.premultiply  = cfg_data_i[0];
        default: ;
      endcase
      if (cfg_index_i <= trd_pkg::RegPremultiply) begin
        load_d       = 1'b1;
        expect_hdr_d = 1'b1;
        is_repeat_d  = 1'b0;
        pkt_left_d   = 8'd0;
        byte_idx_d   = 2'd0;
      end
    end else if (accept) begin
      if (cfg_q.rle_mode && expect_hdr_q) begin
        is_repeat_d  = data_byte_i[7];
        pkt_left_d   = (data_byte_i & trd_pkg::HdrCountMask) + 8'd1;
        expect_hdr_d = 1'b0;
        byte_idx_d   = 2'd0;
      end else if (byte_idx_q < last_idx) begin
        unique case (byte_idx_q)
          2'd0:    held_d[7:0]   = data_byte_i;
          2'd1:    held_d[15:8]  = data_byte_i;
          2'd2:    held_d[23:16] = data_byte_i;
          default: ;
        endcase
        byte_idx_d = byte_idx_q + 2'd1;
      end else begin
        q_ctl_o.push = 1'b1;
        byte_idx_d   = 2'd0;
        pkt_left_d   = pkt_left_nxt;
        pix_left_d   = pix_left_nxt;
        if (cfg_q.rle_mode && pkt_left_nxt == 8'd0) begin
          expect_hdr_d = 1'b1;
        end
        if (pix_left_nxt == '0) begin
          expect_hdr_d = 1'b1;
          is_repeat_d  = 1'b0;
          pkt_left_d   = 8'd0;
          pix_left_d   = total_pix;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= trd_pkg::DimW'(1);
      cfg_q.image_height <= trd_pkg::DimW'(1);
      cfg_q.rle_mode     <= 1'b0;
      cfg_q.has_alpha    <= 1'b0;
      cfg_q.premultiply  <= 1'b0;
      load_q             <= 1'b0;
      expect_hdr_q       <= 1'b1;
      is_repeat_q        <= 1'b0;
      pkt_left_q         <= 8'd0;
      byte_idx_q         <= 2'd0;
      pix_left_q         <= trd_pkg::PixCntW'(1);
    end else begin
      cfg_q        <= cfg_d;
      load_q       <= load_d;
      expect_hdr_q <= expect_hdr_d;
      is_repeat_q  <= is_repeat_d;
      pkt_left_q   <= pkt_left_d;
      byte_idx_q   <= byte_idx_d;
      pix_left_q   <= pix_left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule
`default_nettype wire

/* rtl/core/trd_queue.sv */
// Short queue of decoded pixels between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module trd_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire trd_pkg::q_status_t ctl_i,
  input  wire trd_pkg::pix_t      item_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    valid_o,
  output trd_pkg::pix_t           item_o
);

  trd_pkg::pix_t                 mem_q [trd_pkg::QDepth];
  logic [trd_pkg::QPtrW-1:0]     wptr_q, wptr_d;
  logic [trd_pkg::QPtrW-1:0]     rptr_q, rptr_d;
  logic [trd_pkg::QPtrW:0]       cnt_q, cnt_d;
  logic                          do_push, do_pop;

  assign full_o  = (cnt_q == (trd_pkg::QPtrW + 1)'(trd_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rptr_q];
  assign do_push = ctl_i.push && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == trd_pkg::QPtrW'(trd_pkg::QDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == trd_pkg::QPtrW'(trd_pkg::QDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/trd_back.sv */
// Back end: alpha premultiply pipeline and the result output register.
`timescale 1ns / 1ps
`default_nettype none
module trd_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  wire trd_pkg::pix_t q_item_i,
  output logic               q_pop_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o,
  output logic [7:0]         alpha_o,
  output logic [7:0]         repeat_count_o,
  output logic               image_done_o,
  output logic               run_clipped_o
);

  trd_pkg::prod_t  s1_q, s1_d;
  logic            s1_v_q, s1_v_d;
  logic            s2_v_q, s2_v_d;
  logic [7:0]      scale;
  logic            s2_load;
  logic            s1_load;

  assign s2_load = s1_v_q && (!s2_v_q || pop_i);
  assign s1_load = !s1_v_q || s2_load;
  assign q_pop_o = q_valid_i && s1_load;
  assign empty_o = !s2_v_q;

  // Without premultiply the channel is scaled by 255/255, which returns it unchanged.
  assign scale = q_item_i.premultiply ? q_item_i.alpha : trd_pkg::OpaqueAlpha;

  always_comb begin
    s1_d.red_prod     = 16'(q_item_i.red) * 16'(scale);
    s1_d.green_prod   = 16'(q_item_i.green) * 16'(scale);
    s1_d.blue_prod    = 16'(q_item_i.blue) * 16'(scale);
    s1_d.alpha        = q_item_i.alpha;
    s1_d.repeat_count = q_item_i.repeat_count;
    s1_d.image_done   = q_item_i.image_done;
    s1_d.run_clipped  = q_item_i.run_clipped;
    s1_v_d            = s1_load ? q_valid_i : s1_v_q;
    s2_v_d            = s2_load ? 1'b1 : (pop_i ? 1'b0 : s2_v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_q <= s1_d;
    end
    if (s2_load) begin
      red_o          <= trd_pkg::div255(s1_q.red_prod);
      green_o        <= trd_pkg::div255(s1_q.green_prod);
      blue_o         <= trd_pkg::div255(s1_q.blue_prod);
      alpha_o        <= s1_q.alpha;
      repeat_count_o <= s1_q.repeat_count;
      image_done_o   <= s1_q.image_done;
      run_clipped_o  <= s1_q.run_clipped;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/tga_rle_pixel_decoder_core.sv */
// Top level of the TGA RLE pixel decoder: front end, pixel queue and back end.
// Takes one data byte per cycle while full is low; a pixel result passes the queue, product and output registers.
// Input stalls while the two-entry pixel queue is full because results are not taken, and while the count reloads.
// Reset is asynchronous and active low; registers return to a 1x1 uncompressed image.
// After a register write, full is high for one cycle while the pixel count reloads.
`timescale 1ns / 1ps
`default_nettype none
module tga_rle_pixel_decoder_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [trd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [trd_pkg::DimW-1:0]    cfg_data_i,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [7:0]                  data_byte_i,
  input  wire logic                        pop,
  output logic                             empty,
  output logic [7:0]                       red_o,
  output logic [7:0]                       green_o,
  output logic [7:0]                       blue_o,
  output logic [7:0]                       alpha_o,
  output logic [7:0]                       repeat_count_o,
  output logic                             image_done_o,
  output logic                             run_clipped_o
);

  trd_pkg::q_status_t q_ctl;
  trd_pkg::pix_t      q_in, q_out;
  logic               q_full, q_valid, q_pop;

  trd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push),
    .data_byte_i (data_byte_i),
    .full_o      (full),
    .q_full_i    (q_full),
    .q_ctl_o     (q_ctl),
    .q_item_o    (q_in)
  );

  trd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (q_ctl),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  trd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (q_out),
    .q_pop_o        (q_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .alpha_o        (alpha_o),
    .repeat_count_o (repeat_count_o),
    .image_done_o   (image_done_o),
    .run_clipped_o  (run_clipped_o)
  );

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (repeat_count_o != 8'd0 && repeat_count_o <= 8'd128))
    else $error("repeat count out of range");

  a_clip_ends_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && run_clipped_o) |-> image_done_o)
    else $error("clipped run does not end the image");

  a_cfg_reload_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o && cfg_index_i <= trd_pkg::RegPremultiply) |=> full)
    else $error("input taken while the pixel count reloads");

  a_queue_backs_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_full && !q_pop) |=> full)
    else $error("input taken while the pixel queue is full");

endmodule
`default_nettype wire
